// ===== rtl/core/tse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_pkg
// request and result types, row update codes for the topological sort engine
// ----------------------------------------------------------------------------
package tse_pkg;

  // widest vertex index a row update can carry (64 vertices)
  localparam int unsigned MAX_IDW = 6;

  typedef struct packed {
    logic [4:0] vertex;
    logic [4:0] dep_vertex;
    logic       has_dep;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [4:0] sorted_vertex;
    logic       loop_error;
    logic       final_res;
  } out_item_t;

  // row update codes
  localparam logic ROW_SET = 1'b0;
  localparam logic ROW_CLR = 1'b1;

  typedef struct packed {
    logic               code;
    logic [MAX_IDW-1:0] idx;
  } row_op_t;

  typedef struct packed {
    logic hit;   // addressed bit was set before the update
    logic zero;  // row is empty after the update
  } row_stat_t;

endpackage

// ===== rtl/core/tse_row_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_row_unit
// shared row update: sets or clears one dependency bit and flags the result
// ----------------------------------------------------------------------------
module tse_row_unit #(
  parameter int unsigned NUM_VERTICES = 32
) (
  input  logic [NUM_VERTICES-1:0] row_in,
  input  tse_pkg::row_op_t        op,
  output logic [NUM_VERTICES-1:0] row_out,
  output tse_pkg::row_stat_t      stat
);
  import tse_pkg::*;

  localparam int unsigned IDW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;

  logic [NUM_VERTICES-1:0] mask;

  always_comb begin
    mask = '0;
    mask[op.idx[IDW-1:0]] = 1'b1;
    unique case (op.code)
      ROW_SET: row_out = row_in | mask;
      ROW_CLR: row_out = row_in & ~mask;
      default: row_out = row_in;
    endcase
    stat.hit  = |(row_in & mask);
    stat.zero = ~|row_out;
  end

endmodule

// ===== rtl/core/topological_sort_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topological_sort_engine_top
// loads a dependency graph one request at a time, then runs a kahn sort and
// streams the vertex order, or a single loop error result
// ----------------------------------------------------------------------------
//
//  channel | ports                       | direction | payload
//  --------+-----------------------------+-----------+--------------------------
//  in      | in_valid, in_stall, in_data | into core | vertex, dep_vertex,
//          |                             |           | has_dep, last
//  out     | out_valid, out_stall,       | from core | sorted_vertex, loop_error,
//          | out_data                    |           | final_res
//
//  each loaded request is a row read, then a row write to the matrix
//  after the last request the sort first seeds the queue with one pass over
//  all vertices, then for each queued vertex scans the rows and updates each
//  row that still has bits set, and last reads each result from the queue
//  reset is synchronous, active low; it clears flags and pointers, the
//  matrix rows read as zero until written since each row has a nonzero flag
//  in_stall is high while a request is written and from the last one until the
//  results are queued; out_stall holds the output register; the core waits
//  before each result
module topological_sort_engine_top #(
  parameter int unsigned NUM_VERTICES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tse_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tse_pkg::out_item_t out_data
);
  import tse_pkg::*;

  localparam int unsigned IDW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int unsigned CW  = $clog2(NUM_VERTICES + 1);
  localparam logic [IDW-1:0] LAST_IDX = IDW'(NUM_VERTICES - 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LOAD_WR  = 4'd1;
  localparam logic [3:0] ST_SEED     = 4'd2;
  localparam logic [3:0] ST_PROC_HD  = 4'd3;
  localparam logic [3:0] ST_PROC_X   = 4'd4;
  localparam logic [3:0] ST_PROC_RD  = 4'd5;
  localparam logic [3:0] ST_PROC_WR  = 4'd6;
  localparam logic [3:0] ST_CHECK    = 4'd7;
  localparam logic [3:0] ST_OUT_RD   = 4'd8;
  localparam logic [3:0] ST_OUT_WR   = 4'd9;
  localparam logic [3:0] ST_ERR      = 4'd10;
  localparam logic [3:0] ST_DONE     = 4'd11;

  logic [3:0] state_r, state_nxt;

  in_item_t item_r, item_nxt;

  // per-vertex flags
  logic [NUM_VERTICES-1:0] declared_r, declared_nxt;
  logic [NUM_VERTICES-1:0] blocked_r, blocked_nxt;
  logic [NUM_VERTICES-1:0] row_nz_r, row_nz_nxt;

  logic [IDW-1:0] idx_r, idx_nxt;
  logic [IDW-1:0] x_r, x_nxt;
  logic [CW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  tail_r, tail_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // dependency matrix, one row per vertex
  logic [NUM_VERTICES-1:0] row_mem [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] row_rd_r;
  logic                    row_nz_rd_r;
  logic [IDW-1:0]          row_raddr;
  logic [IDW-1:0]          row_waddr;
  logic                    row_we;

  // order queue
  logic [IDW-1:0] q_mem [NUM_VERTICES];
  logic [IDW-1:0] q_rd_r;
  logic [IDW-1:0] q_raddr;
  logic [IDW-1:0] q_waddr;
  logic [IDW-1:0] q_wdata;
  logic           q_we;

  // shared row unit
  logic [NUM_VERTICES-1:0] row_eff;
  logic [NUM_VERTICES-1:0] row_new;
  row_op_t                 row_op;
  row_stat_t               row_stat;

  logic [IDW-1:0] v_idx;
  logic           v_ok;
  logic           d_ok;
  logic           slot_free;
  logic           last_out;

  // a row without its nonzero flag reads as empty
  assign row_eff = row_nz_rd_r ? row_rd_r : '0;

  tse_row_unit #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_row_unit (
    .row_in  (row_eff),
    .op      (row_op),
    .row_out (row_new),
    .stat    (row_stat)
  );

  assign v_idx     = IDW'(item_r.vertex);
  assign v_ok      = 8'(item_r.vertex) < 8'(NUM_VERTICES);
  assign d_ok      = 8'(item_r.dep_vertex) < 8'(NUM_VERTICES);
  assign slot_free = !out_valid_r || !out_stall;
  assign last_out  = (CW'(idx_r) + CW'(1)) == tail_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    declared_nxt  = declared_r;
    blocked_nxt   = blocked_r;
    row_nz_nxt    = row_nz_r;
    idx_nxt       = idx_r;
    x_nxt         = x_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    row_raddr = idx_r;
    row_waddr = idx_r;
    row_we    = 1'b0;
    q_raddr   = head_r[IDW-1:0];
    q_waddr   = tail_r[IDW-1:0];
    q_wdata   = idx_r;
    q_we      = 1'b0;

    row_op.code = ROW_CLR;
    row_op.idx  = MAX_IDW'(x_r);

    unique case (state_r)
      ST_IDLE: begin
        // look up the row of the incoming vertex straight away
        row_raddr = IDW'(in_data.vertex);
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_LOAD_WR;
        end
      end

      ST_LOAD_WR: begin
        row_op.code = ROW_SET;
        row_op.idx  = MAX_IDW'(item_r.dep_vertex);
        row_waddr   = v_idx;
        if (v_ok) begin
          declared_nxt[v_idx] = 1'b1;
          if (item_r.has_dep) begin
            if (d_ok) begin
              row_we            = 1'b1;
              row_nz_nxt[v_idx] = 1'b1;
            end else begin
              // dependency on an id that can never be declared
              blocked_nxt[v_idx] = 1'b1;
            end
          end
        end
        if (item_r.last) begin
          idx_nxt   = '0;
          head_nxt  = '0;
          tail_nxt  = '0;
          state_nxt = ST_SEED;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SEED: begin
        // queue every declared vertex that is free, ascending id
        if (declared_r[idx_r] && !row_nz_r[idx_r] && !blocked_r[idx_r]) begin
          q_we     = 1'b1;
          tail_nxt = tail_r + CW'(1);
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_PROC_HD;
        end else begin
          idx_nxt = idx_r + IDW'(1);
        end
      end

      ST_PROC_HD: begin
        if (head_r == tail_r) begin
          state_nxt = ST_CHECK;
        end else begin
          head_nxt  = head_r + CW'(1);
          state_nxt = ST_PROC_X;
        end
      end

      ST_PROC_X: begin
        x_nxt     = q_rd_r;
        idx_nxt   = '0;
        state_nxt = ST_PROC_RD;
      end

      ST_PROC_RD: begin
        // only rows that still hold a dependency need the matrix
        if (declared_r[idx_r] && row_nz_r[idx_r]) begin
          state_nxt = ST_PROC_WR;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_PROC_HD;
        end else begin
          idx_nxt = idx_r + IDW'(1);
        end
      end

      ST_PROC_WR: begin
        if (row_stat.hit) begin
          row_we             = 1'b1;
          row_nz_nxt[idx_r]  = !row_stat.zero;
          if (row_stat.zero && !blocked_r[idx_r]) begin
            q_we     = 1'b1;
            tail_nxt = tail_r + CW'(1);
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_PROC_HD;
        end else begin
          idx_nxt   = idx_r + IDW'(1);
          state_nxt = ST_PROC_RD;
        end
      end

      ST_CHECK: begin
        idx_nxt = '0;
        if (|(declared_r & (row_nz_r | blocked_r))) begin
          state_nxt = ST_ERR;
        end else if (tail_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_OUT_RD;
        end
      end

      ST_OUT_RD: begin
        q_raddr = idx_r;
        if (slot_free) begin
          state_nxt = ST_OUT_WR;
        end
      end

      ST_OUT_WR: begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.sorted_vertex = 5'(q_rd_r);
        out_data_nxt.loop_error    = 1'b0;
        out_data_nxt.final_res     = last_out;
        if (last_out) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + IDW'(1);
          state_nxt = ST_OUT_RD;
        end
      end

      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.sorted_vertex = '0;
          out_data_nxt.loop_error    = 1'b1;
          out_data_nxt.final_res     = 1'b1;
          state_nxt                  = ST_DONE;
        end
      end

      ST_DONE: begin
        // drop the graph; stale matrix rows are hidden by the nonzero flags
        declared_nxt = '0;
        blocked_nxt  = '0;
        row_nz_nxt   = '0;
        head_nxt     = '0;
        tail_nxt     = '0;
        state_nxt    = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      declared_r  <= '0;
      blocked_r   <= '0;
      row_nz_r    <= '0;
      idx_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      declared_r  <= declared_nxt;
      blocked_r   <= blocked_nxt;
      row_nz_r    <= row_nz_nxt;
      idx_r       <= idx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    x_r         <= x_nxt;
    out_data_r  <= out_data_nxt;
    row_nz_rd_r <= row_nz_r[row_raddr];
  end

  // matrix memory
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_new;
    end
    row_rd_r <= row_mem[row_raddr];
  end

  // queue memory
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd_r <= q_mem[q_raddr];
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // queue pointers stay ordered and bounded
  a_head_le_tail : assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue head passed tail");

  a_tail_bound : assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= CW'(NUM_VERTICES))
    else $error("queue tail beyond vertex count");

  // a new result only comes from the two result states
  a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && out_stall)) |->
      (state_r == ST_OUT_WR || state_r == ST_ERR))
    else $error("result loaded outside a result state");

  // an error result always closes the run
  a_err_final : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.loop_error) |-> out_data.final_res)
    else $error("loop error result without final mark");

endmodule
